>>> rtl/fa_lru_pkg.sv
// ----------------------------------------------------------------------------
// fa_lru_pkg
// Shared widths, register indexes, result codes and controller/datapath
// command and status types for the fully associative LRU cache core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fa_lru_pkg;

   localparam int ADDR_W       = 32;
   localparam int TAG_W        = 30;
   localparam int STAMP_W      = 32;
   localparam int OFFSET_W     = 3;
   localparam int BLOCKS_W     = 9;
   localparam int CSR_DATA_W   = 9;
   localparam int CSR_IDX_W    = 1;
   localparam int RSP_DATA_W   = 8;
   localparam int KIND_W       = 2;

   localparam int NUM_BLOCKS_DEFAULT = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 1'd1;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 3'd2;
   localparam logic [OFFSET_W-1:0] OFFSET_MIN   = 3'd2;
   localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = 9'd256;

   localparam logic [KIND_W-1:0] KIND_HIT        = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COMPULSORY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CAPACITY   = 2'd2;

   typedef struct packed {
      logic load;
      logic read;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/fa_lru_ctrl.sv
// ----------------------------------------------------------------------------
// fa_lru_ctrl
// Controller: accepts an item, steps the datapath through the entry scan and
// commits the update and result once the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fa_lru_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  fa_lru_pkg::dp_status_type status,
   output fa_lru_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.read   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.read = 1'b1;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/fa_lru_dp.sv
// ----------------------------------------------------------------------------
// fa_lru_dp
// Datapath: config registers, tag and stamp memories, scan compare and
// minimum search, fill and access counters, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fa_lru_dp #(
   parameter int NUM_BLOCKS = fa_lru_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [fa_lru_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fa_lru_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [fa_lru_pkg::ADDR_W-1:0]         req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [fa_lru_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [fa_lru_pkg::KIND_W-1:0]         rsp_tuser,
   input  fa_lru_pkg::ctrl_cmd_type               cmd,
   output fa_lru_pkg::dp_status_type              status
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int NW    = (CNT_W > fa_lru_pkg::BLOCKS_W) ? CNT_W : fa_lru_pkg::BLOCKS_W;

   // config
   logic [fa_lru_pkg::OFFSET_W-1:0] offset_ff, offset_in;
   logic [fa_lru_pkg::BLOCKS_W-1:0] blocks_ff, blocks_in;

   // memories
   logic [fa_lru_pkg::TAG_W-1:0]   tag_mem_ff   [NUM_BLOCKS];
   logic [fa_lru_pkg::STAMP_W-1:0] stamp_mem_ff [NUM_BLOCKS];
   logic [fa_lru_pkg::TAG_W-1:0]   tag_rd_ff;
   logic [fa_lru_pkg::STAMP_W-1:0] stamp_rd_ff;

   // scan state
   logic [fa_lru_pkg::TAG_W-1:0]   blk_ff, blk_in;
   logic [CNT_W-1:0]               rd_idx_ff, rd_idx_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]               cmp_idx_ff, cmp_idx_in;
   logic                           found_ff, found_in;
   logic [IDX_W-1:0]               hit_idx_ff, hit_idx_in;
   logic                           have_ff, have_in;
   logic [fa_lru_pkg::STAMP_W-1:0] min_ff, min_in;
   logic [IDX_W-1:0]               victim_ff, victim_in;

   // counters
   logic [fa_lru_pkg::STAMP_W-1:0] access_ff, access_in;
   logic [CNT_W-1:0]               filled_ff, filled_in;

   // result register
   logic                           rsp_vld_ff, rsp_vld_in;
   logic                           hit_ff, hit_in;
   logic [fa_lru_pkg::KIND_W-1:0]  kind_ff, kind_in;

   logic [fa_lru_pkg::OFFSET_W-1:0] shift_eff;
   logic [fa_lru_pkg::ADDR_W-1:0]   addr_shifted;
   logic [NW-1:0]                   blocks_ext;
   logic [NW-1:0]                   n_wide;
   logic [CNT_W-1:0]                n_eff;
   logic [CNT_W-1:0]                scan_len;
   logic                            not_full;
   logic                            wr_en;
   logic [IDX_W-1:0]                wr_idx;

   assign shift_eff    = (offset_ff < fa_lru_pkg::OFFSET_MIN) ? fa_lru_pkg::OFFSET_MIN
                                                                 : offset_ff;
   assign addr_shifted = req_tdata >> shift_eff;

   assign blocks_ext = NW'(blocks_ff);
   always_comb begin
      if (blocks_ext == '0) begin
         n_wide = NW'(1);
      end else if (blocks_ext > NW'(NUM_BLOCKS)) begin
         n_wide = NW'(NUM_BLOCKS);
      end else begin
         n_wide = blocks_ext;
      end
   end
   assign n_eff    = n_wide[CNT_W-1:0];
   assign scan_len = (filled_ff < n_eff) ? filled_ff : n_eff;
   assign not_full = (filled_ff < n_eff);

   assign status.scan_done = (rd_idx_ff == scan_len);
   assign status.out_free  = !rsp_vld_ff || rsp_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(fa_lru_pkg::RSP_DATA_W-1){1'b0}}, hit_ff};
   assign rsp_tuser  = kind_ff;

   always_comb begin
      offset_in = offset_ff;
      blocks_in = blocks_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fa_lru_pkg::CSR_OFFSET_BITS:   offset_in = csr_wdata[fa_lru_pkg::OFFSET_W-1:0];
            fa_lru_pkg::CSR_BLOCKS_IN_USE: blocks_in = csr_wdata[fa_lru_pkg::BLOCKS_W-1:0];
            default: ;
         endcase
      end
   end

   // scan: one read per cycle, compare and min search in the cycle after each read
   always_comb begin
      blk_in     = blk_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      hit_idx_in = hit_idx_ff;
      have_in    = have_ff;
      min_in     = min_ff;
      victim_in  = victim_ff;
      if (cmd.load) begin
         blk_in    = addr_shifted[fa_lru_pkg::TAG_W-1:0];
         rd_idx_in = '0;
         found_in  = 1'b0;
         have_in   = 1'b0;
      end else begin
         if (cmd.read) begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = rd_idx_ff[IDX_W-1:0];
            rd_idx_in  = rd_idx_ff + CNT_W'(1);
         end
         if (cmp_vld_ff) begin
            if (!found_ff && (tag_rd_ff == blk_ff)) begin
               found_in   = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (!have_ff || (stamp_rd_ff < min_ff)) begin
               have_in   = 1'b1;
               min_in    = stamp_rd_ff;
               victim_in = cmp_idx_ff;
            end
         end
      end
   end

   // commit
   always_comb begin
      access_in  = access_ff;
      filled_in  = filled_ff;
      rsp_vld_in = rsp_vld_ff;
      hit_in     = hit_ff;
      kind_in    = kind_ff;
      wr_en      = 1'b0;
      wr_idx     = victim_ff;
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      if (found_ff) begin
         wr_idx = hit_idx_ff;
      end else if (not_full) begin
         wr_idx = filled_ff[IDX_W-1:0];
      end
      if (cmd.commit) begin
         wr_en      = 1'b1;
         access_in  = access_ff + fa_lru_pkg::STAMP_W'(1);
         rsp_vld_in = 1'b1;
         hit_in     = found_ff;
         if (found_ff) begin
            kind_in = fa_lru_pkg::KIND_HIT;
         end else if (not_full) begin
            kind_in = fa_lru_pkg::KIND_COMPULSORY;
            if (filled_ff != CNT_W'(NUM_BLOCKS)) begin
               filled_in = filled_ff + CNT_W'(1);
            end
         end else begin
            kind_in = fa_lru_pkg::KIND_CAPACITY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[wr_idx]   <= blk_ff;
         stamp_mem_ff[wr_idx] <= access_ff;
      end
      if (cmd.read) begin
         tag_rd_ff   <= tag_mem_ff[rd_idx_ff[IDX_W-1:0]];
         stamp_rd_ff <= stamp_mem_ff[rd_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      blk_ff     <= blk_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_idx_ff <= hit_idx_in;
      min_ff     <= min_in;
      victim_ff  <= victim_in;
      hit_ff     <= hit_in;
      kind_ff    <= kind_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= fa_lru_pkg::OFFSET_RESET;
         blocks_ff  <= fa_lru_pkg::BLOCKS_RESET;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         have_ff    <= 1'b0;
         access_ff  <= '0;
         filled_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         offset_ff  <= offset_in;
         blocks_ff  <= blocks_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
         have_ff    <= have_in;
         access_ff  <= access_in;
         filled_ff  <= filled_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

endmodule

>>> rtl/fully_assoc_lru_cache_core.sv
// ----------------------------------------------------------------------------
// fully_assoc_lru_cache_core
// Each accepted address is looked up in a fully associative tag store with
// LRU replacement and gives one result: hit flag and miss kind (hit,
// compulsory fill, capacity eviction). The tag and stamp memories are read
// one entry per cycle for the compare and least-recent search, over L =
// min(entries in use, entries filled so far) entries; no new item is accepted
// until the result is committed. Entries fill in index order, so a fill count
// stands in for valid bits and no clearing pass follows reset. A new item is
// accepted while the previous result still waits in the output register. The
// user must write registers only while the core is idle; it is not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fully_assoc_lru_cache_core #(
   parameter int NUM_BLOCKS = fa_lru_pkg::NUM_BLOCKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fa_lru_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fa_lru_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fa_lru_pkg::ADDR_W-1:0]     req_tdata,   // [31:0] address
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fa_lru_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [0] hit, [7:1] zero
   output logic [fa_lru_pkg::KIND_W-1:0]     rsp_tuser    // [1:0] miss_kind
);

   fa_lru_pkg::ctrl_cmd_type  cmd;
   fa_lru_pkg::dp_status_type status;

   fa_lru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fa_lru_dp #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.read, cmd.commit}))
      else $error("controller issued overlapping commands");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("new item accepted during a lookup");

   a_hit_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tuser == fa_lru_pkg::KIND_HIT)))
      else $error("hit flag disagrees with miss kind");

   a_commit_frees_ctrl: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (req_tready && rsp_tvalid))
      else $error("commit did not post a result and return to idle");

endmodule
